// ----- rtl/gn2d_pkg.sv -----
package gn2d_pkg;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // register map
   localparam int PADDR_W = 4;
   localparam logic [1:0] REG_GRID_COLS   = 2'd0;
   localparam logic [1:0] REG_RECIP_WIDTH = 2'd1;
   localparam logic [1:0] REG_RECIP_HEIGHT = 2'd2;

   // raw corner index width, wide enough for any col, row and stride
   localparam int RAW_W = 11;
   // width of a corner dot product
   localparam int DOT_W = 34;
   // fade in Q0.16 spans 0..65536
   localparam int FADE_W = 17;

   // load enables of the fade pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } fade_adv_type;

   // shift right with rounding half away from zero
   function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned s);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] q;
      half = 64'd1 << (s - 1);
      mag  = v[63] ? 64'(-v) : 64'(v);
      q    = (mag + half) >> s;
      return v[63] ? -$signed(q) : $signed(q);
   endfunction

   // dot product of a gradient with a distance vector
   function automatic logic signed [DOT_W-1:0] dot_product(logic signed [15:0] gx,
                                                           logic signed [15:0] gy,
                                                           logic signed [16:0] vx,
                                                           logic signed [16:0] vy);
      logic signed [32:0] px;
      logic signed [32:0] py;
      px = gx * vx;
      py = gy * vy;
      return $signed({px[32], px}) + $signed({py[32], py});
   endfunction

   // x + round((y - x) * a / 2^16)
   function automatic logic signed [DOT_W-1:0] mix(logic signed [DOT_W-1:0] x,
                                                   logic signed [DOT_W-1:0] y,
                                                   logic [FADE_W-1:0] a);
      logic signed [DOT_W:0]        diff;
      logic signed [DOT_W+FADE_W+1:0] prod;
      logic signed [63:0]           r;
      diff = $signed({y[DOT_W-1], y}) - $signed({x[DOT_W-1], x});
      prod = diff * $signed({1'b0, a});
      r    = round_shift(64'(prod), 16);
      return DOT_W'(64'(x) + r);
   endfunction

endpackage

// ----- rtl/gn2d_req_if.sv -----
interface gn2d_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [4:0]         cell_col;
   logic [4:0]         cell_row;
   logic [7:0]         offset_x;
   logic [7:0]         offset_y;
   logic signed [15:0] grad_x;
   logic signed [15:0] grad_y;

   modport source (output valid, command, cell_col, cell_row, offset_x, offset_y,
                   grad_x, grad_y, input ready);
   modport sink (input valid, command, cell_col, cell_row, offset_x, offset_y,
                 grad_x, grad_y, output ready);
endinterface

// ----- rtl/gn2d_rsp_if.sv -----
interface gn2d_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

// ----- rtl/gn2d_corner_mem.sv -----
module gn2d_corner_mem #(
   parameter int DEPTH  = 289,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr [4],
   output logic [31:0]       rd_data [4]
);

   // two copies of the corner table, two read ports each
   logic [31:0] mem_near [DEPTH];
   logic [31:0] mem_far  [DEPTH];

   // both copies take every load
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_near[wr_addr] <= wr_data;
         mem_far[wr_addr]  <= wr_data;
      end
   end

   // registered reads, held while the first stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data[0] <= mem_near[rd_addr[0]];
         rd_data[1] <= mem_near[rd_addr[1]];
         rd_data[2] <= mem_far[rd_addr[2]];
         rd_data[3] <= mem_far[rd_addr[3]];
      end
   end

endmodule

// ----- rtl/gn2d_fade.sv -----
module gn2d_fade (
   input  logic                          clock,
   input  gn2d_pkg::fade_adv_type        adv,
   input  logic [15:0]                   t_in,
   output logic [gn2d_pkg::FADE_W-1:0]   fade_out
);
   import gn2d_pkg::*;

   logic [15:0]       t2_ff, ta_ff;
   logic [15:0]       t3_ff, tb_ff;
   logic [15:0]       t4_ff, t3b_ff, tc_ff;
   logic [15:0]       t5_ff, t4c_ff, t3c_ff;
   logic [FADE_W-1:0] fade_ff;
   logic [23:0]       pos_sum;
   logic [23:0]       neg_sum;
   logic [23:0]       fade_diff;
   logic [FADE_W-1:0] fade_in;

   // round(a * b / 2^16), the result stays below 2^16
   function automatic logic [15:0] mul_q16(logic [15:0] a, logic [15:0] b);
      logic [32:0] p;
      p = 33'(32'(a) * 32'(b)) + 33'd32768;
      return p[31:16];
   endfunction

   // power chain, one multiply per stage
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         t2_ff <= mul_q16(t_in, t_in);
         ta_ff <= t_in;
      end
      if (adv.s3) begin
         t3_ff <= mul_q16(t2_ff, ta_ff);
         tb_ff <= ta_ff;
      end
      if (adv.s4) begin
         t4_ff  <= mul_q16(t3_ff, tb_ff);
         t3b_ff <= t3_ff;
         tc_ff  <= tb_ff;
      end
      if (adv.s5) begin
         t5_ff  <= mul_q16(t4_ff, tc_ff);
         t4c_ff <= t4_ff;
         t3c_ff <= t3b_ff;
      end
      if (adv.s6) begin
         fade_ff <= fade_in;
      end
   end

   // 6t^5 - 15t^4 + 10t^3 clamped to 0..1
   always_comb begin
      pos_sum   = 24'(t5_ff) * 24'd6 + 24'(t3c_ff) * 24'd10;
      neg_sum   = 24'(t4c_ff) * 24'd15;
      fade_diff = pos_sum - neg_sum;
      if (neg_sum > pos_sum) begin
         fade_in = '0;
      end else if (fade_diff > 24'd65536) begin
         fade_in = FADE_W'(65536);
      end else begin
         fade_in = fade_diff[FADE_W-1:0];
      end
   end

   assign fade_out = fade_ff;

endmodule

// ----- rtl/gradient_noise_2d.sv -----
// 2D gradient noise, one transaction per clock unless the result port stalls. A load transaction
// (command 0) writes a gradient into the corner table at col + row * (grid_cols + 1) and gives
// no result; an evaluate transaction (command 1) gives one noise value, and a new transaction
// can be taken every cycle while earlier ones are in flight, unless the result port stalls. The
// rate is set by the corner table, kept in two copies with two read ports each so that
// all four corners of a cell are read in the same cycle. Loads out of the table are dropped
// and corners out of the table count as zero gradients. The table holds no defined value
// until loaded, so every corner an evaluation reaches must be loaded first. A stalled
// result port lets the pipeline fill behind it before the input side stops.
module gradient_noise_2d #(
   parameter int MAX_GRID_COLS = 16,
   parameter int MAX_GRID_ROWS = 16,
   parameter int MAX_CELL_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   gn2d_req_if.sink                      req_bus,
   gn2d_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gn2d_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import gn2d_pkg::*;

   localparam int DEPTH   = (MAX_GRID_COLS + 1) * (MAX_GRID_ROWS + 1);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int OFS_MAX = (MAX_CELL_SIZE - 1 > 255) ? 255 : MAX_CELL_SIZE - 1;
   localparam int LAST    = 9;

   logic [4:0]  grid_cols_ff;
   logic [15:0] recip_w_ff;
   logic [15:0] recip_h_ff;
   logic        csr_write;
   logic [1:0]  reg_idx;

   logic [LAST+1:1] adv;
   logic [LAST:1]   valid_ff;
   logic            req_accept;
   logic            eval_accept;
   logic            load_wr;

   logic [5:0]       stride;
   logic [RAW_W-1:0] idx [4];
   logic [3:0]       idx_ok;
   logic [ADDR_W-1:0] rd_addr [4];
   logic [31:0]      rd_data [4];
   logic [7:0]       ofs_x, ofs_y;
   logic [23:0]      prod_x, prod_y;
   logic [15:0]      fx_in, fy_in;

   logic [3:0]       ok_s1_ff;
   logic [15:0]      fx_s1_ff, fy_s1_ff;
   logic signed [DOT_W-1:0] d_ff [2:6][4];
   logic signed [15:0] gx [4];
   logic signed [15:0] gy [4];
   logic signed [16:0] vx0, vx1, vy0, vy1;

   fade_adv_type      fade_adv;
   logic [FADE_W-1:0] ux, uy;
   logic [FADE_W-1:0] uy_s7_ff;
   logic signed [DOT_W-1:0] top_ff, bot_ff, n_ff;
   logic signed [63:0] r_full;
   logic [15:0]       out_in, out_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= 5'd1;
         recip_w_ff   <= 16'hFFFF;
         recip_h_ff   <= 16'hFFFF;
      end else if (csr_write) begin
         case (reg_idx)
            REG_GRID_COLS: begin
               grid_cols_ff <= pwdata[4:0];
            end
            REG_RECIP_WIDTH: begin
               recip_w_ff <= pwdata[15:0];
            end
            REG_RECIP_HEIGHT: begin
               recip_h_ff <= pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRID_COLS:    prdata = {27'b0, grid_cols_ff};
         REG_RECIP_WIDTH:  prdata = {16'b0, recip_w_ff};
         REG_RECIP_HEIGHT: prdata = {16'b0, recip_h_ff};
         default:          prdata = '0;
      endcase
   end

   // pipeline flow: a stage loads when empty or when the next one moves
   always_comb begin
      adv[LAST+1] = rsp_bus.ready;
      for (int k = LAST; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[1];
   assign req_accept    = req_bus.valid && adv[1];
   assign eval_accept   = req_accept && (req_bus.command == CMD_EVAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= eval_accept;
         end
         for (int k = 2; k <= LAST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // corner indices, linear so the last column wraps into the next row
   always_comb begin
      stride = {1'b0, grid_cols_ff} + 6'd1;
      idx[0] = RAW_W'(req_bus.cell_col) + RAW_W'(req_bus.cell_row) * RAW_W'(stride);
      idx[1] = idx[0] + RAW_W'(1);
      idx[2] = idx[0] + RAW_W'(stride);
      idx[3] = idx[2] + RAW_W'(1);
      for (int i = 0; i < 4; i++) begin
         idx_ok[i]  = 32'(idx[i]) < 32'(DEPTH);
         rd_addr[i] = ADDR_W'(idx[i]);
      end
   end

   assign load_wr = req_accept && (req_bus.command == CMD_LOAD) && idx_ok[0];

   gn2d_corner_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_corner_mem (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (rd_addr[0]),
      .wr_data ({req_bus.grad_x, req_bus.grad_y}),
      .rd_en   (adv[1]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // fractions inside the cell, saturated
   always_comb begin
      ofs_x  = (32'(req_bus.offset_x) > 32'(OFS_MAX)) ? 8'(OFS_MAX) : req_bus.offset_x;
      ofs_y  = (32'(req_bus.offset_y) > 32'(OFS_MAX)) ? 8'(OFS_MAX) : req_bus.offset_y;
      prod_x = 24'(ofs_x) * 24'(recip_w_ff);
      prod_y = 24'(ofs_y) * 24'(recip_h_ff);
      fx_in  = (|prod_x[23:16]) ? 16'hFFFF : prod_x[15:0];
      fy_in  = (|prod_y[23:16]) ? 16'hFFFF : prod_y[15:0];
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ok_s1_ff <= idx_ok;
         fx_s1_ff <= fx_in;
         fy_s1_ff <= fy_in;
      end
   end

   // stage 2: four corner dot products
   always_comb begin
      vx0 = $signed({1'b0, fx_s1_ff});
      vx1 = $signed({1'b1, fx_s1_ff});
      vy0 = $signed({1'b0, fy_s1_ff});
      vy1 = $signed({1'b1, fy_s1_ff});
      for (int i = 0; i < 4; i++) begin
         gx[i] = ok_s1_ff[i] ? $signed(rd_data[i][31:16]) : 16'sd0;
         gy[i] = ok_s1_ff[i] ? $signed(rd_data[i][15:0])  : 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         d_ff[2][0] <= dot_product(gx[0], gy[0], vx0, vy0);
         d_ff[2][1] <= dot_product(gx[1], gy[1], vx1, vy0);
         d_ff[2][2] <= dot_product(gx[2], gy[2], vx0, vy1);
         d_ff[2][3] <= dot_product(gx[3], gy[3], vx1, vy1);
      end
      for (int k = 3; k <= 6; k++) begin
         if (adv[k]) begin
            d_ff[k] <= d_ff[k-1];
         end
      end
   end

   // stages 2 to 6: fade curves
   always_comb begin
      fade_adv.s2 = adv[2];
      fade_adv.s3 = adv[3];
      fade_adv.s4 = adv[4];
      fade_adv.s5 = adv[5];
      fade_adv.s6 = adv[6];
   end

   gn2d_fade u_fade_x (
      .clock    (clock),
      .adv      (fade_adv),
      .t_in     (fx_s1_ff),
      .fade_out (ux)
   );

   gn2d_fade u_fade_y (
      .clock    (clock),
      .adv      (fade_adv),
      .t_in     (fy_s1_ff),
      .fade_out (uy)
   );

   // stages 7 and 8: bilinear mix
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         top_ff   <= mix(d_ff[6][0], d_ff[6][1], ux);
         bot_ff   <= mix(d_ff[6][2], d_ff[6][3], ux);
         uy_s7_ff <= uy;
      end
      if (adv[8]) begin
         n_ff <= mix(top_ff, bot_ff, uy_s7_ff);
      end
   end

   // stage 9: map to 0.5 * n + 0.5 and saturate
   always_comb begin
      r_full = round_shift(64'(n_ff), 15) + 64'sd32768;
      if (r_full < 64'sd0) begin
         out_in = '0;
      end else if (r_full > 64'sd65535) begin
         out_in = 16'hFFFF;
      end else begin
         out_in = r_full[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = valid_ff[LAST];
   assign rsp_bus.noise_value = out_ff;

`ifndef ASSERT_OFF
   // a load never produces a pipeline entry
   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.command == CMD_LOAD) |=> !valid_ff[1])
      else $error("load transaction entered the pipeline");

   // an evaluate always produces a pipeline entry
   a_eval_entry: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.command == CMD_EVAL) |=> valid_ff[1])
      else $error("evaluate transaction lost at entry");

   // a stalled middle stage keeps its entry
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[5] && !adv[5]) |=> valid_ff[5])
      else $error("stalled pipeline entry dropped");

   // fade weights stay within one
   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> (ux <= FADE_W'(65536) && uy <= FADE_W'(65536)))
      else $error("fade weight out of range");

   // table writes stay inside the table
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      load_wr |-> (32'(rd_addr[0]) < 32'(DEPTH)))
      else $error("corner table write out of range");
`endif

endmodule
